// ===== rtl/core/stereo_feedback_delay_assert.svh =====
`ifndef STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_ASSERT_SVH

// Clocked assertion, ignored while reset is held low
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define SFD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sfd_pkg.sv =====
package sfd_pkg;

  // Sample format: signed Q0.23
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int DELAY_W  = 17;
  localparam int FRAC_W   = 14;

  // Echo store geometry (power-of-two depth, address wraps naturally)
  localparam int ADDR_W = 17;
  localparam int DEPTH  = 1 << ADDR_W;

  // Product of a Q2.14 gain and a sample, and that product after the shift
  localparam int PROD_W   = GAIN_W + 1 + SAMPLE_W;
  localparam int SCALED_W = PROD_W - FRAC_W;
  localparam int SUM_W    = SCALED_W + 1;

  // Output queue
  localparam int OFIFO_AW    = 2;
  localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_DELAY    = 2'd0;
  localparam logic [1:0] REG_DRY      = 2'd1;
  localparam logic [1:0] REG_WET      = 2'd2;
  localparam logic [1:0] REG_FEEDBACK = 2'd3;

  localparam logic [DELAY_W-1:0] DELAY_RST    = DELAY_W'(24000);
  localparam logic [GAIN_W-1:0]  DRY_RST      = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0]  WET_RST      = GAIN_W'(8192);
  localparam logic [GAIN_W-1:0]  FEEDBACK_RST = GAIN_W'(5734);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_samples;
    logic [GAIN_W-1:0]  dry_gain;
    logic [GAIN_W-1:0]  wet_gain;
    logic [GAIN_W-1:0]  feedback_gain;
  } cfg_t;

  // Pipeline occupancy reported by the core
  typedef struct packed {
    logic s1_busy;
    logic s2_busy;
  } flight_t;

  // floor(gain * sample / 2^14)
  function automatic scaled_t scale_q14(logic [GAIN_W-1:0] gain, sample_t s);
    logic signed [PROD_W-1:0] prod;
    prod = $signed({1'b0, gain}) * s;
    return prod[PROD_W-1:FRAC_W];
  endfunction

  function automatic sample_t sat24(logic signed [SUM_W-1:0] v);
    sample_t res;
    if (v > $signed({{(SUM_W-SAMPLE_W){1'b0}}, SAMPLE_MAX})) begin
      res = SAMPLE_MAX;
    end else if (v < $signed({{(SUM_W-SAMPLE_W){1'b1}}, SAMPLE_MIN})) begin
      res = SAMPLE_MIN;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_sample(sample_t s);
    return {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_scaled(scaled_t s);
    return {s[SCALED_W-1], s};
  endfunction

endpackage

// ===== rtl/core/sfd_in_if.sv =====
interface sfd_in_if;
  import sfd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/core/sfd_out_if.sv =====
interface sfd_out_if;
  import sfd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/core/sfd_cfg_regs.sv =====
module sfd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::CFG_AW-1:0] paddr,
  input  logic [sfd_pkg::CFG_DW-1:0] pwdata,
  output logic [sfd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output sfd_pkg::cfg_t              cfg
);
  import sfd_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DELAY:    cfg_nxt.delay_samples = pwdata[DELAY_W-1:0];
        REG_DRY:      cfg_nxt.dry_gain      = pwdata[GAIN_W-1:0];
        REG_WET:      cfg_nxt.wet_gain      = pwdata[GAIN_W-1:0];
        REG_FEEDBACK: cfg_nxt.feedback_gain = pwdata[GAIN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_samples <= DELAY_RST;
      cfg_r.dry_gain      <= DRY_RST;
      cfg_r.wet_gain      <= WET_RST;
      cfg_r.feedback_gain <= FEEDBACK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // readback
  always_comb begin
    case (reg_idx)
      REG_DELAY:    prdata = CFG_DW'(cfg_r.delay_samples);
      REG_DRY:      prdata = CFG_DW'(cfg_r.dry_gain);
      REG_WET:      prdata = CFG_DW'(cfg_r.wet_gain);
      REG_FEEDBACK: prdata = CFG_DW'(cfg_r.feedback_gain);
      default:      prdata = '0;
    endcase
  end
endmodule

// ===== rtl/core/sfd_echo_core.sv =====
// Echo store and its read-modify-write pipeline.
//   accept: read the delayed entry, capture sample and hazard flags
//   S1:     pick delayed word, feedback sum written back, gains applied
//   S2:     output sum and saturation, word pushed to the output queue
module sfd_echo_core (
  input  logic             clk,
  input  logic             rst_n,
  input  sfd_pkg::cfg_t    cfg,
  input  logic             in_accept,
  input  sfd_pkg::pair_t   in_word,
  output logic             push,
  output sfd_pkg::pair_t   push_word,
  output sfd_pkg::flight_t flight
);
  import sfd_pkg::*;

  pair_t mem [DEPTH];

  // write position and fill tracking (entries at or past wp are unwritten until wrap)
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [ADDR_W-1:0] rd_addr;

  // stage 1
  logic              v1_r;
  pair_t             x1_r;
  logic [ADDR_W-1:0] wp1_r;
  logic              fwd1_r;
  logic              fill1_r;
  pair_t             rd_data_r;
  pair_t             st_r;
  pair_t             delayed;
  pair_t             st_nxt;

  // stage 2
  logic    v2_r;
  scaled_t dry_l_r, dry_r_r, wet_l_r, wet_r_r;

  assign rd_addr = wp_r - cfg.delay_samples[ADDR_W-1:0];

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (in_accept) begin
      wp_nxt = wp_r + ADDR_W'(1);
      if (wp_r == ADDR_W'(DEPTH - 1)) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      v1_r      <= in_accept;
      v2_r      <= v1_r;
    end
  end

  // store: write-back from S1, registered read for the new word
  always_ff @(posedge clk) begin
    if (v1_r) begin
      mem[wp1_r] <= st_nxt;
    end
    rd_data_r <= mem[rd_addr];
  end

  // stage 1 capture; forward when the word ahead writes the entry being read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x1_r    <= in_word;
      wp1_r   <= wp_r;
      fwd1_r  <= v1_r && (rd_addr == wp1_r);
      fill1_r <= wrapped_r || (rd_addr < wp_r);
    end
    st_r <= st_nxt;
  end

  // delayed sample select: forwarded, stored, or cleared entry
  always_comb begin
    if (fwd1_r) begin
      delayed = st_r;
    end else if (fill1_r) begin
      delayed = rd_data_r;
    end else begin
      delayed = '0;
    end
  end

  // feedback sum into the store
  always_comb begin
    st_nxt.left  = sat24(ext_sample(x1_r.left)
                         + ext_scaled(scale_q14(cfg.feedback_gain, delayed.left)));
    st_nxt.right = sat24(ext_sample(x1_r.right)
                         + ext_scaled(scale_q14(cfg.feedback_gain, delayed.right)));
  end

  // dry and wet products
  always_ff @(posedge clk) begin
    dry_l_r <= scale_q14(cfg.dry_gain, x1_r.left);
    dry_r_r <= scale_q14(cfg.dry_gain, x1_r.right);
    wet_l_r <= scale_q14(cfg.wet_gain, delayed.left);
    wet_r_r <= scale_q14(cfg.wet_gain, delayed.right);
  end

  // stage 2: output mix
  assign push            = v2_r;
  assign push_word.left  = sat24(ext_scaled(dry_l_r) + ext_scaled(wet_l_r));
  assign push_word.right = sat24(ext_scaled(dry_r_r) + ext_scaled(wet_r_r));

  assign flight.s1_busy = v1_r;
  assign flight.s2_busy = v2_r;
endmodule

// ===== rtl/core/sfd_out_fifo.sv =====
// Small output queue; also the output register
module sfd_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  sfd_pkg::pair_t            push_word,
  input  logic                      pop,
  output logic                      not_empty,
  output sfd_pkg::pair_t            head_word,
  output logic [sfd_pkg::OFIFO_AW:0] count
);
  import sfd_pkg::*;

  pair_t               slots [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OFIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OFIFO_AW:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign head_word = slots[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OFIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + OFIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (OFIFO_AW + 1)'(push) - (OFIFO_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_word;
    end
  end
endmodule

// ===== rtl/core/stereo_feedback_delay.sv =====
// Channel   Dir  Words                        Handshake
// in_ch     in   left_in, right_in  (Q0.23)   valid/ready
// out_ch    out  left_out, right_out (Q0.23)  valid/ready
// APB cfg   in   delay, dry, wet, feedback    psel/penable, pready high
//
// One word per cycle sustained while out_ch keeps taking words; the loop store write,
// forward mux, feedback multiply sets that pace. A taken word passes S1, S2, then the queue.
// Reset is synchronous; the store needs no clearing pass, unwritten entries read as
// zero from the write-position fill tracking. in_ch.ready drops only when the
// four-entry output queue, counting words still in the pipeline, would overflow.
module stereo_feedback_delay (
  input  logic                       clk,
  input  logic                       rst_n,
  sfd_in_if.sink                     in_ch,
  sfd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::CFG_AW-1:0] paddr,
  input  logic [sfd_pkg::CFG_DW-1:0] pwdata,
  output logic [sfd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import sfd_pkg::*;

  cfg_t              cfg;
  flight_t           flight;
  logic              in_accept;
  pair_t             in_word;
  logic              push;
  pair_t             push_word;
  pair_t             head_word;
  logic              not_empty;
  logic [OFIFO_AW:0] q_count;
  logic [OFIFO_AW+1:0] occupancy;

  sfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // room check covers words already in flight
  assign occupancy    = {1'b0, q_count} + (OFIFO_AW + 2)'(flight.s1_busy)
                        + (OFIFO_AW + 2)'(flight.s2_busy);
  assign in_ch.ready  = (occupancy < (OFIFO_AW + 2)'(OFIFO_DEPTH));
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_word.left  = in_ch.left_in;
  assign in_word.right = in_ch.right_in;

  sfd_echo_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_accept (in_accept),
    .in_word   (in_word),
    .push      (push),
    .push_word (push_word),
    .flight    (flight)
  );

  sfd_out_fifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (out_ch.ready),
    .not_empty (not_empty),
    .head_word (head_word),
    .count     (q_count)
  );

  assign out_ch.valid     = not_empty;
  assign out_ch.left_out  = head_word.left;
  assign out_ch.right_out = head_word.right;
endmodule

// ===== rtl/core/sfd_checker.sv =====
`include "stereo_feedback_delay_assert.svh"

module sfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sfd_pkg::SAMPLE_W-1:0] out_left,
  input logic [sfd_pkg::SAMPLE_W-1:0] out_right,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [sfd_pkg::CFG_AW-1:0] paddr,
  input logic [sfd_pkg::CFG_DW-1:0] pwdata,
  input logic [sfd_pkg::CFG_DW-1:0] prdata
);
  import sfd_pkg::*;

  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite;

  // reset empties the pipeline and the output queue
  `SFD_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid right after reset")

  // a taken word is shown once it has passed S1, S2 and the output queue write
  `SFD_ASSERT(a_latency, clk, rst_n, in_valid && in_ready |-> ##3 out_valid, "word lost in pipeline")

  // a stalled word holds
  `SFD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right), "stalled output changed")

  // a register write reads back on the next cycle
  `SFD_ASSERT(a_cfg_readback, clk, rst_n, cfg_wr ##1 (psel && !pwrite && paddr[3:2] == $past(paddr[3:2])) |-> prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0]), "register readback mismatch")
endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_out),
  .out_right (out_ch.right_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

// ===== verif/stereo_feedback_delay_tb.sv =====
module stereo_feedback_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst_n;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  stereo_feedback_delay dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Echo predictor state: its own store, write pointer and register copy
  bit signed [SAMPLE_W-1:0] echo_left  [DEPTH];
  bit signed [SAMPLE_W-1:0] echo_right [DEPTH];
  logic [ADDR_W-1:0]        echo_wr_pos = '0;
  cfg_t                     echo_cfg = '{DELAY_RST, DRY_RST, WET_RST, FEEDBACK_RST};
  pair_t                    expected_pairs[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_cycles = 0;
  int          mismatch_count = 0;
  int          stall_cycles = 0;

  // floor(gain * sample / 2^14)
  function automatic longint gain_product(logic [GAIN_W-1:0] gain, sample_t s);
    longint p;
    p = longint'(gain) * longint'(s);
    return p >>> FRAC_W;
  endfunction

  function automatic sample_t clamp_sample(longint v);
    if (v > 64'sd8388607) begin
      return SAMPLE_MAX;
    end
    if (v < -64'sd8388608) begin
      return SAMPLE_MIN;
    end
    return sample_t'(v);
  endfunction

  // Read the tap, form the output, write input plus feedback, advance the pointer
  function automatic void predict_echo(pair_t x);
    logic [ADDR_W-1:0] rd_pos;
    sample_t           tap_l;
    sample_t           tap_r;
    pair_t             y;
    rd_pos = echo_wr_pos - echo_cfg.delay_samples;
    tap_l = echo_left[rd_pos];
    tap_r = echo_right[rd_pos];
    y.left  = clamp_sample(gain_product(echo_cfg.dry_gain, x.left) +
                           gain_product(echo_cfg.wet_gain, tap_l));
    y.right = clamp_sample(gain_product(echo_cfg.dry_gain, x.right) +
                           gain_product(echo_cfg.wet_gain, tap_r));
    echo_left[echo_wr_pos]  = clamp_sample(longint'(x.left) +
                                           gain_product(echo_cfg.feedback_gain, tap_l));
    echo_right[echo_wr_pos] = clamp_sample(longint'(x.right) +
                                           gain_product(echo_cfg.feedback_gain, tap_r));
    echo_wr_pos = echo_wr_pos + 1'b1;
    expected_pairs.push_back(y);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(15))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return -1;
      4, 5: return sample_t'(int'($urandom_range(4000)) - 2000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain(int unsigned soft_max);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return GAIN_W'(16384);
      3, 4: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(soft_max));
    endcase
  endfunction

  // Mostly short delays so the echoes come back within a phase
  function automatic cfg_t rand_echo_cfg();
    cfg_t c;
    case ($urandom_range(9))
      0: c.delay_samples = '0;
      1: c.delay_samples = '1;
      2: c.delay_samples = DELAY_W'($urandom);
      3: c.delay_samples = DELAY_W'($urandom_range(1000));
      default: c.delay_samples = DELAY_W'($urandom_range(40, 1));
    endcase
    c.dry_gain      = rand_gain(20000);
    c.wet_gain      = rand_gain(20000);
    c.feedback_gain = rand_gain(12000);
    return c;
  endfunction

  // Receiver: random ready, or a counted hold-off when asked
  always @(negedge clk) begin
    if (recv_hold_cycles != 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected output word: left_out %0d right_out %0d",
               out_ch.left_out, out_ch.right_out);
        mismatch_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_ch.left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, out_ch.left_out);
          mismatch_count++;
        end
        if (out_ch.right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, out_ch.right_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no word moved for %0d cycles", stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_pair(sample_t l, sample_t r);
    pair_t x;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    x.left  = l;
    x.right = r;
    predict_echo(x);
  endtask

  // Stop sending and wait until every predicted word has come out
  task automatic drain_echoes();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DELAY:    echo_cfg.delay_samples = value[DELAY_W-1:0];
      REG_DRY:      echo_cfg.dry_gain      = value[GAIN_W-1:0];
      REG_WET:      echo_cfg.wet_gain      = value[GAIN_W-1:0];
      REG_FEEDBACK: echo_cfg.feedback_gain = value[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Unused upper bits of each write carry junk
  task automatic set_echo_config(cfg_t c);
    drain_echoes();
    cfg_write(REG_DELAY,    {15'($urandom), c.delay_samples});
    cfg_write(REG_DRY,      {16'($urandom), c.dry_gain});
    cfg_write(REG_WET,      {16'($urandom), c.wet_gain});
    cfg_write(REG_FEEDBACK, {16'($urandom), c.feedback_gain});
  endtask

  task automatic test_reset_defaults();
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, -1);
    send_pair(1, sample_t'(24'h555555));
  endtask

  // Full-scale gains with a one-sample loop: output and store both saturate
  task automatic test_saturation();
    set_echo_config('{delay_samples: 17'd1, dry_gain: 16'hFFFF, wet_gain: 16'hFFFF,
                      feedback_gain: 16'hFFFF});
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(-1, 1);
    send_pair('0, '0);
  endtask

  // Tiny gains: the shift rounds toward minus infinity
  task automatic test_rounding();
    set_echo_config('{delay_samples: 17'd2, dry_gain: 16'd1, wet_gain: 16'd1,
                      feedback_gain: 16'd0});
    send_pair(-1, 1);
    send_pair(-1, 1);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(3, -3);
  endtask

  // Zero delay reads a whole store length back; also the longest delay
  task automatic test_delay_extremes();
    set_echo_config('{delay_samples: 17'd0, dry_gain: 16'd0, wet_gain: 16'd0,
                      feedback_gain: 16'd0});
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(-1, SAMPLE_MAX);
    send_pair(sample_t'(24'h123456), sample_t'(24'hABCDEF));
    set_echo_config('{delay_samples: 17'h1FFFF, dry_gain: DRY_RST, wet_gain: 16'hFFFF,
                      feedback_gain: 16'hFFFF});
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, '0);
    send_pair(1, -1);
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    set_echo_config('{delay_samples: 17'd3, dry_gain: DRY_RST, wet_gain: WET_RST,
                      feedback_gain: FEEDBACK_RST});
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    recv_hold_cycles = 300;
    repeat (40) send_pair(rand_sample(), rand_sample());
    drain_echoes();
    repeat (10) send_pair(rand_sample(), rand_sample());
  endtask

  task automatic test_random_traffic();
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin send_idle_pct = 31; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        set_echo_config(rand_echo_cfg());
        repeat ($urandom_range(70, 40)) send_pair(rand_sample(), rand_sample());
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_saturation();
    test_rounding();
    test_delay_extremes();
    test_backpressure();
    test_random_traffic();

    // Wait out the pipeline so a stray word would still be caught
    drain_echoes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sfd_pkg.sv
rtl/core/sfd_in_if.sv
rtl/core/sfd_out_if.sv
rtl/core/sfd_cfg_regs.sv
rtl/core/sfd_echo_core.sv
rtl/core/sfd_out_fifo.sv
rtl/core/stereo_feedback_delay.sv
rtl/core/sfd_checker.sv
verif/stereo_feedback_delay_tb.sv
